/* hw/rtl/mod3_mod2_weak_prf_eval_assert.svh */
// Assertion macros shared by the weak PRF evaluator RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef MOD3_MOD2_WEAK_PRF_EVAL_ASSERT_SVH
`define MOD3_MOD2_WEAK_PRF_EVAL_ASSERT_SVH

// Stage stalled by its consumer keeps its contents on the next edge.
`define WPRF_ASSERT_HOLD(lbl, clk, rst_n, stall, data) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (stall) |=> $stable(data)) \
        else $error("stalled stage changed its contents");

// Generic next-cycle implication.
`define WPRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Signal is low on the edge after reset is applied.
`define WPRF_ASSERT_RST(lbl, clk, rst_n, sig) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> !(sig)) \
        else $error("signal not cleared by reset");

`endif

/* hw/rtl/wprf_pkg.sv */
// Package for the mod-3/mod-2 weak PRF evaluator: sizes, codes, item types
// and the mod-3 adder. No dependencies.
`default_nettype none

package wprf_pkg;

    localparam int KEY_BITS   = 128;
    localparam int OUT_ROWS   = 128;
    localparam int WORD_W     = 64;
    localparam int ROW_WORDS  = 4;
    localparam int MAT_ROWS   = 128;
    localparam int ROW_IDX_W  = 7;
    localparam int WORD_IDX_W = 2;
    localparam int GRP_W      = 8;
    localparam int NUM_GRP    = KEY_BITS / GRP_W;
    localparam int HALF_GRP   = NUM_GRP / 2;
    localparam int PP_W       = WORD_W / GRP_W;
    localparam int RES_BITS   = 128;
    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 128;
    localparam int CFG_IDX_W  = 1;

    localparam logic MODE_EVAL = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

    typedef logic [1:0] t_trit;

    typedef struct packed {
        logic                  mode;
        logic [ROW_IDX_W-1:0]  row_index;
        logic [WORD_IDX_W-1:0] word_index;
        logic [WORD_W-1:0]     table_word;
    } t_ld;

    typedef struct packed {
        t_ld                 ld;
        logic [KEY_BITS-1:0] h;
    } t_h_item;

    typedef struct packed {
        t_ld                 ld;
        logic [KEY_BITS-1:0] w;
    } t_w_item;

    function automatic t_trit add3(t_trit a, t_trit b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/wprf_wgen.sv */
// Three-stage pipeline building w (bit set where the mod-3 running count of h is 1).
// Depends on wprf_pkg and the assertion macro header.
`default_nettype none
`include "mod3_mod2_weak_prf_eval_assert.svh"

module wprf_wgen (
    input  wire                logic     i_clk,
    input  wire                logic     i_rst_n,
    input  wire                logic     i_valid,
    output logic                         o_ready,
    input  wire                wprf_pkg::t_h_item i_item,
    output logic                         o_valid,
    input  wire                logic     i_ready,
    output wprf_pkg::t_w_item            o_item
);

    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    wprf_pkg::t_ld     r_ld1;
    wprf_pkg::t_ld     r_ld2;
    wprf_pkg::t_ld     r_ld3;

    logic [wprf_pkg::KEY_BITS-1:0][1:0] r_lp1;
    logic [wprf_pkg::KEY_BITS-1:0][1:0] n_lp1;
    logic [wprf_pkg::KEY_BITS-1:0][1:0] r_lp2;
    logic [wprf_pkg::NUM_GRP-1:0][1:0]  r_off2;
    logic [wprf_pkg::NUM_GRP-1:0][1:0]  n_off2;
    wprf_pkg::t_trit                    r_htot2;
    wprf_pkg::t_trit                    n_htot2;
    logic [wprf_pkg::KEY_BITS-1:0]      r_w3;
    logic [wprf_pkg::KEY_BITS-1:0]      n_w3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_item  = '{ld: r_ld3, w: r_w3};

    // stage 1: running count inside each 8-bit group
    always_comb begin
        wprf_pkg::t_trit acc;
        n_lp1 = '0;
        for (int g = 0; g < wprf_pkg::NUM_GRP; g++) begin
            acc = 2'd0;
            for (int j = 0; j < wprf_pkg::GRP_W; j++) begin
                acc = wprf_pkg::add3(acc, {1'b0, i_item.h[g*wprf_pkg::GRP_W + j]});
                n_lp1[g*wprf_pkg::GRP_W + j] = acc;
            end
        end
    end

    // stage 2: group offsets inside each half, plus total of the low half
    always_comb begin
        wprf_pkg::t_trit acc_lo;
        wprf_pkg::t_trit acc_hi;
        n_off2 = '0;
        acc_lo = 2'd0;
        acc_hi = 2'd0;
        for (int g = 0; g < wprf_pkg::HALF_GRP; g++) begin
            n_off2[g] = acc_lo;
            acc_lo = wprf_pkg::add3(acc_lo, r_lp1[g*wprf_pkg::GRP_W + wprf_pkg::GRP_W - 1]);
            n_off2[g + wprf_pkg::HALF_GRP] = acc_hi;
            acc_hi = wprf_pkg::add3(acc_hi,
                r_lp1[(g + wprf_pkg::HALF_GRP)*wprf_pkg::GRP_W + wprf_pkg::GRP_W - 1]);
        end
        n_htot2 = acc_lo;
    end

    // stage 3: full count per bit; w bit is set when the trit is 1
    always_comb begin
        wprf_pkg::t_trit base;
        wprf_pkg::t_trit u;
        n_w3 = '0;
        for (int g = 0; g < wprf_pkg::NUM_GRP; g++) begin
            base = wprf_pkg::add3(r_off2[g], (g >= wprf_pkg::HALF_GRP) ? r_htot2 : 2'd0);
            for (int j = 0; j < wprf_pkg::GRP_W; j++) begin
                u = wprf_pkg::add3(r_lp2[g*wprf_pkg::GRP_W + j], base);
                n_w3[g*wprf_pkg::GRP_W + j] = (u == 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ld1 <= i_item.ld;
            r_lp1 <= n_lp1;
        end
        if (rdy2) begin
            r_ld2   <= r_ld1;
            r_lp2   <= r_lp1;
            r_off2  <= n_off2;
            r_htot2 <= n_htot2;
        end
        if (rdy3) begin
            r_ld3 <= r_ld2;
            r_w3  <= n_w3;
        end
    end

    `WPRF_ASSERT_HOLD(a_w3_hold, i_clk, i_rst_n, r_v3 && !i_ready, r_w3)

endmodule

`default_nettype wire

/* hw/rtl/wprf_mat.sv */
// Matrix store and two-stage row parity: partial parities, then final bits.
// Depends on wprf_pkg and the assertion macro header.
`default_nettype none
`include "mod3_mod2_weak_prf_eval_assert.svh"

module wprf_mat (
    input  wire  logic                              i_clk,
    input  wire  logic                              i_rst_n,
    input  wire  logic                              i_valid,
    output logic                                    o_ready,
    input  wire  wprf_pkg::t_w_item                 i_item,
    output logic                                    o_valid,
    input  wire  logic                              i_ready,
    output logic [wprf_pkg::RES_BITS-1:0]           o_prf
);

    logic rdy4;
    logic rdy5;
    logic wr_en;
    logic ev_in;

    logic [wprf_pkg::WORD_W-1:0] r_mat [wprf_pkg::MAT_ROWS][wprf_pkg::ROW_WORDS];

    logic                                              r_v4;
    logic                                              r_v5;
    logic [wprf_pkg::OUT_ROWS-1:0][wprf_pkg::PP_W-1:0] r_pp;
    logic [wprf_pkg::OUT_ROWS-1:0][wprf_pkg::PP_W-1:0] n_pp;
    logic [wprf_pkg::RES_BITS-1:0]                     r_prf;
    logic [wprf_pkg::RES_BITS-1:0]                     n_prf;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign o_ready = rdy4;
    assign wr_en   = i_valid && rdy4 && (i_item.ld.mode == wprf_pkg::MODE_LOAD);
    assign ev_in   = i_valid && (i_item.ld.mode == wprf_pkg::MODE_EVAL);
    assign o_valid = r_v5;
    assign o_prf   = r_prf;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mat[i_item.ld.row_index][i_item.ld.word_index] <= i_item.ld.table_word;
        end
    end

    // w repeats every 128 bits, so row words 0/2 and 1/3 fold before the AND
    always_comb begin
        logic [wprf_pkg::WORD_W-1:0] v;
        n_pp = '0;
        for (int i = 0; i < wprf_pkg::OUT_ROWS; i++) begin
            v = ((r_mat[i][0] ^ r_mat[i][2]) & i_item.w[wprf_pkg::WORD_W-1:0])
              ^ ((r_mat[i][1] ^ r_mat[i][3]) & i_item.w[wprf_pkg::KEY_BITS-1:wprf_pkg::WORD_W]);
            for (int p = 0; p < wprf_pkg::PP_W; p++) begin
                n_pp[i][p] = ^v[p*wprf_pkg::GRP_W +: wprf_pkg::GRP_W];
            end
        end
    end

    always_comb begin
        n_prf = '0;
        for (int i = 0; i < wprf_pkg::OUT_ROWS; i++) begin
            n_prf[i] = ^r_pp[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy4) begin
                r_v4 <= ev_in;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_pp <= n_pp;
        end
        if (rdy5) begin
            r_prf <= n_prf;
        end
    end

    `WPRF_ASSERT_HOLD(a_pp_hold, i_clk, i_rst_n, r_v4 && !rdy5, r_pp)
    `WPRF_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, wr_en, !r_v4)

endmodule

`default_nettype wire

/* hw/rtl/mod3_mod2_weak_prf_eval.sv */
// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata 208b, tuser 1b (mode)
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata 128b
// cfg       in   i_cfg_valid / o_cfg_ready          index 1b, data 64b
//
// One item per cycle sustained while m_axis is ready; an evaluation result passes the input
// register, three w-build stages, partial parity and final parity in that order.
// A load writes its matrix word when it reaches the parity stage and yields no result.
// Reset clears the key and all valid bits; matrix words are undefined until loaded.
// Each stage holds while the next one is full, so stalls drop and repeat nothing.
// Depends on wprf_pkg, wprf_wgen, wprf_mat and the assertion macro header.
`default_nettype none
`include "mod3_mod2_weak_prf_eval_assert.svh"

module mod3_mod2_weak_prf_eval (
    input  wire  logic                                i_clk,
    input  wire  logic                                i_rst_n,
    input  wire  logic                                i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // [63:0] x_low, [127:64] x_high, [134:128] row_index,
    // [136:135] word_index, [200:137] table_word, [207:201] zero
    input  wire  logic [wprf_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [0] mode
    input  wire  logic                                i_s_axis_tuser,
    output logic                                      o_m_axis_tvalid,
    input  wire  logic                                i_m_axis_tready,
    // [63:0] prf_low, [127:64] prf_high
    output logic [wprf_pkg::OUT_DATA_W-1:0]           o_m_axis_tdata,
    input  wire  logic                                i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire  logic [wprf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  logic [wprf_pkg::WORD_W-1:0]         i_cfg_data
);

    logic [wprf_pkg::KEY_BITS-1:0] r_key;
    logic                          r_v0;
    wprf_pkg::t_h_item             r_item0;
    wprf_pkg::t_h_item             n_item0;
    logic                          s0_rdy;
    logic                          wg_rdy;
    logic                          wg_valid;
    wprf_pkg::t_w_item             wg_item;
    logic                          mat_rdy;
    logic [wprf_pkg::KEY_BITS-1:0] x_in;

    assign o_cfg_ready     = 1'b1;
    assign s0_rdy          = !r_v0 || wg_rdy;
    assign o_s_axis_tready = s0_rdy;

    assign x_in = i_s_axis_tdata[wprf_pkg::KEY_BITS-1:0];

    always_comb begin
        n_item0.ld.mode       = i_s_axis_tuser;
        n_item0.ld.row_index  = i_s_axis_tdata[134:128];
        n_item0.ld.word_index = i_s_axis_tdata[136:135];
        n_item0.ld.table_word = i_s_axis_tdata[200:137];
        n_item0.h             = r_key & x_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wprf_pkg::CFG_KEY_LOW: begin
                    r_key[wprf_pkg::WORD_W-1:0] <= i_cfg_data;
                end
                wprf_pkg::CFG_KEY_HIGH: begin
                    r_key[wprf_pkg::KEY_BITS-1:wprf_pkg::WORD_W] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s0_rdy) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_rdy) begin
            r_item0 <= n_item0;
        end
    end

    wprf_wgen u_wgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .o_ready (wg_rdy),
        .i_item  (r_item0),
        .o_valid (wg_valid),
        .i_ready (mat_rdy),
        .o_item  (wg_item)
    );

    wprf_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wg_valid),
        .o_ready (mat_rdy),
        .i_item  (wg_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_prf   (o_m_axis_tdata)
    );

    `WPRF_ASSERT_HOLD(a_s0_hold, i_clk, i_rst_n, r_v0 && !wg_rdy, r_item0)
    `WPRF_ASSERT_RST(a_rst_out, i_clk, i_rst_n, o_m_axis_tvalid)

endmodule

`default_nettype wire
